@@ rtl/core/keyed_conflict_edge_grouper_defines.svh @@
// assertion helpers for the edge grouper
`ifndef KEYED_CONFLICT_EDGE_GROUPER_DEFINES_SVH
`define KEYED_CONFLICT_EDGE_GROUPER_DEFINES_SVH
`define KCEG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define KCEG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`endif

@@ rtl/core/kceg_pkg.sv @@
package kceg_pkg;
   localparam int unsigned DIGEST_BITS = 256;
   localparam int unsigned WORD_BITS = 64;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_IGNORED = 3'd1;
   localparam logic [2:0] ST_LIST_FULL = 3'd2;
   localparam logic [2:0] ST_TABLE_FULL = 3'd3;
   localparam logic [2:0] ST_READ_INVALID = 3'd4;

   localparam logic REQ_RECORD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [0:0] REG_SUPPORT_MASK = 1'b0;
   localparam logic [0:0] REG_CONTRA_MASK = 1'b1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SEARCH = 6'b000010,
      S_DECIDE = 6'b000100,
      S_READ = 6'b001000,
      S_READ_DATA = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] record_index;
      logic created;
      logic polarity;
      logic [2:0] edge_slot;
      logic [3:0] support_count;
      logic [3:0] contradiction_count;
      logic [4:0] record_count;
   } result_type;
endpackage

@@ rtl/core/kceg_key_compare.sv @@
module kceg_key_compare
   import kceg_pkg::*;
(
   input  logic [DIGEST_BITS-1:0] stored_key,
   input  logic [DIGEST_BITS-1:0] probe_key,
   output logic match
);
   assign match = (stored_key == probe_key);
endmodule

@@ rtl/core/keyed_conflict_edge_grouper.sv @@
// Edge grouper for target-keyed incidences. Each transaction is handled alone; ready (stall low)
// is only shown in idle. Keys sit in a memory with a registered read, so each key is first read
// and then compared on the shared 256-bit comparator. A record transaction compares the keys in
// order up to and including the match, or all n records in use when the key is new; none when
// the table is empty. Ignored classes and reads of an unused record go straight to the result.
// The result is held while rsp_stall is high. Stores are undefined after reset except for
// counts, which reset clears; no clearing pass is needed.
module keyed_conflict_edge_grouper
   import kceg_pkg::*;
#(
   parameter int unsigned RECORD_SLOTS = 16,
   parameter int unsigned EDGES_PER_KIND = 8,
   parameter int unsigned CLASS_COUNT = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [3:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_req_type,
   input  logic [5:0] req_relation_class,
   input  logic [63:0] req_node_digest_w0,
   input  logic [63:0] req_node_digest_w1,
   input  logic [63:0] req_node_digest_w2,
   input  logic [63:0] req_node_digest_w3,
   input  logic [63:0] req_source_digest_w0,
   input  logic [63:0] req_source_digest_w1,
   input  logic [63:0] req_source_digest_w2,
   input  logic [63:0] req_source_digest_w3,
   input  logic [3:0] req_read_record,
   input  logic [4:0] req_read_slot,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [3:0] rsp_record_index,
   output logic rsp_created,
   output logic rsp_polarity,
   output logic [2:0] rsp_edge_slot,
   output logic [3:0] rsp_support_count,
   output logic [3:0] rsp_contradiction_count,
   output logic [4:0] rsp_record_count,
   output logic [63:0] rsp_data_w0,
   output logic [63:0] rsp_data_w1,
   output logic [63:0] rsp_data_w2,
   output logic [63:0] rsp_data_w3
);
`include "keyed_conflict_edge_grouper_defines.svh"
   localparam int unsigned RW = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
   localparam int unsigned CW = $clog2(RECORD_SLOTS + 1);
   localparam int unsigned EW = (EDGES_PER_KIND > 1) ? $clog2(EDGES_PER_KIND) : 1;
   localparam int unsigned NW = $clog2(EDGES_PER_KIND + 1);
   localparam int unsigned AW = RW + EW;
   localparam int unsigned EDGE_DEPTH = RECORD_SLOTS << EW;

   logic [63:0] sup_mask_ff, con_mask_ff;
   logic [DIGEST_BITS-1:0] key_mem [RECORD_SLOTS];
   logic [DIGEST_BITS-1:0] sup_mem [EDGE_DEPTH];
   logic [DIGEST_BITS-1:0] con_mem [EDGE_DEPTH];
   logic [NW-1:0] sup_cnt_ff [RECORD_SLOTS];
   logic [NW-1:0] con_cnt_ff [RECORD_SLOTS];
   logic [CW-1:0] used_ff;

   state_type state_ff;
   logic [DIGEST_BITS-1:0] key_ff, src_ff, key_rd_ff, edge_rd_ff, data_ff;
   logic is_sup_ff;
   logic [RW-1:0] scan_ff, rec_ff;
   logic [4:0] slot_ff;
   logic [3:0] rrec_ff;
   logic first_ff;
   result_type res_ff;
   logic match;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == REG_CONTRA_MASK) ? con_mask_ff : sup_mask_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sup_mask_ff <= '0;
         con_mask_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == 4'd0) sup_mask_ff <= csr_pwdata;
         else if (csr_paddr == 4'd8) con_mask_ff <= csr_pwdata;
      end
   end

   kceg_key_compare u_cmp (.stored_key(key_rd_ff), .probe_key(key_ff), .match(match));

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   wire req_acc = req_valid && !req_stall;
   wire [5:0] cls = req_relation_class;
   wire cls_ok = (32'(cls) < CLASS_COUNT);
   wire sup_hit = cls_ok && sup_mask_ff[cls];
   wire con_hit = cls_ok && !sup_hit && con_mask_ff[cls];
   wire rrec_use = (CW'(req_read_record) < used_ff) && (32'(req_read_record) < RECORD_SLOTS);
   wire [RW-1:0] rr = RW'(req_read_record);
   wire [RW-1:0] rrec_idx = RW'(rrec_ff);
   wire rd_req = (req_req_type == REQ_READ);

   logic [RW-1:0] key_addr;
   logic [AW-1:0] edge_addr;
   logic rd_con;
   always_comb begin
      key_addr = scan_ff;
      if (state_ff == S_IDLE) key_addr = '0;
      if (state_ff == S_READ) key_addr = rrec_idx;
      rd_con = (32'(slot_ff) > EDGES_PER_KIND);
      edge_addr = {rrec_idx, rd_con ? EW'(32'(slot_ff) - EDGES_PER_KIND - 1)
                                    : EW'(32'(slot_ff) - 1)};
   end

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[key_addr];
      edge_rd_ff <= rd_con ? con_mem[edge_addr] : sup_mem[edge_addr];
   end

   wire [NW-1:0] cur_cnt = is_sup_ff ? sup_cnt_ff[rec_ff] : con_cnt_ff[rec_ff];
   wire cnt_room = (32'(cur_cnt) < EDGES_PER_KIND);
   wire [AW-1:0] wr_addr = {rec_ff, cur_cnt[EW-1:0]};

   always_ff @(posedge clock) begin
      if (state_ff == S_DECIDE && !first_ff && cnt_room) begin
         if (is_sup_ff) sup_mem[wr_addr] <= src_ff;
         else con_mem[wr_addr] <= src_ff;
      end
      if (state_ff == S_SEARCH && !first_ff && !match && CW'(scan_ff) + 1'b1 >= used_ff
          && used_ff < CW'(RECORD_SLOTS))
         key_mem[used_ff[RW-1:0]] <= key_ff;
      if (state_ff == S_SEARCH && first_ff && used_ff == '0) key_mem['0] <= key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         for (int i = 0; i < RECORD_SLOTS; i++) begin
            sup_cnt_ff[i] <= '0;
            con_cnt_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: if (req_acc) begin
               key_ff <= {req_node_digest_w3, req_node_digest_w2,
                          req_node_digest_w1, req_node_digest_w0};
               src_ff <= {req_source_digest_w3, req_source_digest_w2,
                          req_source_digest_w1, req_source_digest_w0};
               is_sup_ff <= sup_hit;
               scan_ff <= '0;
               first_ff <= 1'b1;
               rrec_ff <= req_read_record;
               slot_ff <= req_read_slot;
               data_ff <= '0;
               res_ff <= {rd_req ? ST_READ_INVALID : ST_IGNORED,
                          rd_req ? req_read_record : 4'd0,
                          1'b0, 1'b0, 3'd0,
                          (rd_req && rrec_use) ? 4'(sup_cnt_ff[rr]) : 4'd0,
                          (rd_req && rrec_use) ? 4'(con_cnt_ff[rr]) : 4'd0,
                          5'(used_ff)};
               if (rd_req) begin
                  state_ff <= rrec_use ? S_READ : S_DONE;
               end else if (!sup_hit && !con_hit) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               // first cycle waits on the key read; then read and compare alternate
               if (first_ff) begin
                  if (used_ff == '0) begin
                     rec_ff <= '0;
                     res_ff.created <= 1'b1;
                     used_ff <= used_ff + 1'b1;
                     sup_cnt_ff[0] <= '0;
                     con_cnt_ff[0] <= '0;
                     first_ff <= 1'b1;
                     state_ff <= S_DECIDE;
                  end else begin
                     first_ff <= 1'b0;
                  end
               end else if (match) begin
                  rec_ff <= scan_ff;
                  first_ff <= 1'b1;
                  state_ff <= S_DECIDE;
               end else if (CW'(scan_ff) + 1'b1 >= used_ff) begin
                  if (used_ff >= CW'(RECORD_SLOTS)) begin
                     res_ff.status <= ST_TABLE_FULL;
                     state_ff <= S_DONE;
                  end else begin
                     rec_ff <= used_ff[RW-1:0];
                     res_ff.created <= 1'b1;
                     sup_cnt_ff[used_ff[RW-1:0]] <= '0;
                     con_cnt_ff[used_ff[RW-1:0]] <= '0;
                     used_ff <= used_ff + 1'b1;
                     first_ff <= 1'b1;
                     state_ff <= S_DECIDE;
                  end
               end else begin
                  scan_ff <= scan_ff + 1'b1;
                  first_ff <= 1'b1;
               end
            end
            S_DECIDE: begin
               // a settle step first so the fresh counts are seen
               if (first_ff) begin
                  first_ff <= 1'b0;
               end else begin
                  res_ff.record_index <= 4'(rec_ff);
                  res_ff.polarity <= !is_sup_ff;
                  res_ff.record_count <= 5'(used_ff);
                  res_ff.status <= cnt_room ? ST_OK : ST_LIST_FULL;
                  res_ff.edge_slot <= cnt_room ? 3'(cur_cnt) : 3'd0;
                  res_ff.support_count <= (cnt_room && is_sup_ff) ? 4'(cur_cnt + 1'b1)
                                                                  : 4'(sup_cnt_ff[rec_ff]);
                  res_ff.contradiction_count <= (cnt_room && !is_sup_ff)
                                                ? 4'(cur_cnt + 1'b1)
                                                : 4'(con_cnt_ff[rec_ff]);
                  if (cnt_room) begin
                     if (is_sup_ff) sup_cnt_ff[rec_ff] <= cur_cnt + 1'b1;
                     else con_cnt_ff[rec_ff] <= cur_cnt + 1'b1;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_READ: state_ff <= S_READ_DATA;
            S_READ_DATA: begin
               state_ff <= S_DONE;
               if (slot_ff == 5'd0) begin
                  res_ff.status <= ST_OK;
                  data_ff <= key_rd_ff;
               end else if (32'(slot_ff) <= EDGES_PER_KIND) begin
                  if (32'(slot_ff) - 1 < 32'(sup_cnt_ff[rrec_idx])) begin
                     res_ff.status <= ST_OK;
                     res_ff.edge_slot <= 3'(32'(slot_ff) - 1);
                     data_ff <= edge_rd_ff;
                  end
               end else if (32'(slot_ff) <= 2 * EDGES_PER_KIND) begin
                  if (32'(slot_ff) - 1 - EDGES_PER_KIND < 32'(con_cnt_ff[rrec_idx])) begin
                     res_ff.status <= ST_OK;
                     res_ff.polarity <= 1'b1;
                     res_ff.edge_slot <= 3'(32'(slot_ff) - EDGES_PER_KIND - 1);
                     data_ff <= edge_rd_ff;
                  end
               end
            end
            S_DONE: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_status = res_ff.status;
   assign rsp_record_index = res_ff.record_index;
   assign rsp_created = res_ff.created;
   assign rsp_polarity = res_ff.polarity;
   assign rsp_edge_slot = res_ff.edge_slot;
   assign rsp_support_count = res_ff.support_count;
   assign rsp_contradiction_count = res_ff.contradiction_count;
   assign rsp_record_count = res_ff.record_count;
   assign rsp_data_w0 = data_ff[63:0];
   assign rsp_data_w1 = data_ff[127:64];
   assign rsp_data_w2 = data_ff[191:128];
   assign rsp_data_w3 = data_ff[255:192];

   `KCEG_ASSERT_IMPL(a_table_bound, clock, reset, 1'b1, used_ff <= CW'(RECORD_SLOTS))
   `KCEG_ASSERT_IMPL(a_ready_only_idle, clock, reset, rsp_valid, req_stall)
   `KCEG_ASSERT_NEXT(a_hold_result, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_status))
endmodule

@@ test/keyed_conflict_edge_grouper_tb.sv @@
module keyed_conflict_edge_grouper_tb;
   import kceg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RECORDS = 16;
   localparam int EDGES = 8;
   localparam int KEY_POOL = 20;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] record_index;
      logic created;
      logic polarity;
      logic [2:0] edge_slot;
      logic [3:0] support_count;
      logic [3:0] contradiction_count;
      logic [4:0] record_count;
      logic [255:0] data;
   } grouper_result_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;
   logic req_valid = 0;
   logic req_stall;
   logic req_req_type = 0;
   logic [5:0] req_relation_class = '0;
   logic [63:0] req_node_digest_w0 = '0, req_node_digest_w1 = '0;
   logic [63:0] req_node_digest_w2 = '0, req_node_digest_w3 = '0;
   logic [63:0] req_source_digest_w0 = '0, req_source_digest_w1 = '0;
   logic [63:0] req_source_digest_w2 = '0, req_source_digest_w3 = '0;
   logic [3:0] req_read_record = '0;
   logic [4:0] req_read_slot = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_status;
   logic [3:0] rsp_record_index;
   logic rsp_created, rsp_polarity;
   logic [2:0] rsp_edge_slot;
   logic [3:0] rsp_support_count, rsp_contradiction_count;
   logic [4:0] rsp_record_count;
   logic [63:0] rsp_data_w0, rsp_data_w1, rsp_data_w2, rsp_data_w3;

   keyed_conflict_edge_grouper dut (.*);

   // predictor state
   logic [63:0] support_mask, contra_mask;
   logic [255:0] key_store [RECORDS];
   logic [255:0] sup_edge_store [RECORDS][EDGES];
   logic [255:0] contra_edges [RECORDS][EDGES];
   int support_cnt [RECORDS];
   int contra_cnt [RECORDS];
   int records_used;

   grouper_result_type pending_results[$];
   logic [255:0] key_pool [KEY_POOL];
   int errors = 0;
   int status_seen [8];
   int results_seen = 0;
   bit idling = 1;
   bit long_hold = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #20ms;
      $display("timeout at %0t", $time);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [255:0] rand_digest();
      logic [255:0] d;
      for (int i = 0; i < 8; i++) d[i*32 +: 32] = $urandom;
      return d;
   endfunction

   function automatic grouper_result_type predict_grouping(logic rtype, logic [5:0] cls,
         logic [255:0] node, logic [255:0] src, logic [3:0] rrec, logic [4:0] rslot);
      grouper_result_type r;
      int rec;
      int p;
      bit sup, con, in_use;
      r = '0;
      if (rtype == REQ_READ) begin
         in_use = rrec < records_used;
         r.record_index = rrec;
         r.record_count = 5'(records_used);
         r.status = ST_READ_INVALID;
         if (in_use) begin
            r.support_count = 4'(support_cnt[rrec]);
            r.contradiction_count = 4'(contra_cnt[rrec]);
            if (rslot == 0) begin
               r.status = ST_OK;
               r.data = key_store[rrec];
            end else if (rslot <= EDGES) begin
               p = rslot - 1;
               if (p < support_cnt[rrec]) begin
                  r.status = ST_OK;
                  r.edge_slot = 3'(p);
                  r.data = sup_edge_store[rrec][p];
               end
            end else if (rslot <= 2 * EDGES) begin
               p = rslot - 1 - EDGES;
               if (p < contra_cnt[rrec]) begin
                  r.status = ST_OK;
                  r.polarity = 1'b1;
                  r.edge_slot = 3'(p);
                  r.data = contra_edges[rrec][p];
               end
            end
         end
         return r;
      end
      sup = support_mask[cls];
      con = !sup && contra_mask[cls];
      r.record_count = 5'(records_used);
      if (!sup && !con) begin
         r.status = ST_IGNORED;
         return r;
      end
      rec = -1;
      for (int c = 0; c < records_used; c++)
         if (rec < 0 && key_store[c] == node) rec = c;
      if (rec < 0) begin
         if (records_used >= RECORDS) begin
            r.status = ST_TABLE_FULL;
            return r;
         end
         rec = records_used;
         key_store[rec] = node;
         support_cnt[rec] = 0;
         contra_cnt[rec] = 0;
         records_used++;
         r.created = 1'b1;
      end
      r.record_index = 4'(rec);
      r.polarity = !sup;
      r.status = ST_LIST_FULL;
      if (sup && support_cnt[rec] < EDGES) begin
         r.edge_slot = 3'(support_cnt[rec]);
         sup_edge_store[rec][support_cnt[rec]] = src;
         support_cnt[rec]++;
         r.status = ST_OK;
      end else if (con && contra_cnt[rec] < EDGES) begin
         r.edge_slot = 3'(contra_cnt[rec]);
         contra_edges[rec][contra_cnt[rec]] = src;
         contra_cnt[rec]++;
         r.status = ST_OK;
      end
      r.support_count = 4'(support_cnt[rec]);
      r.contradiction_count = 4'(contra_cnt[rec]);
      r.record_count = 5'(records_used);
      return r;
   endfunction

   task automatic send_item(logic rtype, logic [5:0] cls, logic [255:0] node,
         logic [255:0] src, logic [3:0] rrec, logic [4:0] rslot);
      @(negedge clock);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_req_type = rtype;
      req_relation_class = cls;
      {req_node_digest_w3, req_node_digest_w2, req_node_digest_w1, req_node_digest_w0} = node;
      {req_source_digest_w3, req_source_digest_w2, req_source_digest_w1,
       req_source_digest_w0} = src;
      req_read_record = rrec;
      req_read_slot = rslot;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_grouping(rtype, cls, node, src, rrec, rslot));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [0:0] reg_index, logic [63:0] value);
      @(negedge clock);
      csr_psel = 1;
      csr_penable = 0;
      csr_pwrite = 1;
      csr_paddr = {reg_index, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      if (reg_index == REG_SUPPORT_MASK) support_mask = value;
      else contra_mask = value;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   task automatic set_masks(logic [63:0] sup, logic [63:0] con);
      wait_idle();
      csr_write(REG_SUPPORT_MASK, sup);
      csr_write(REG_CONTRA_MASK, con);
   endtask

   task automatic send_random_item();
      logic [255:0] node;
      if ($urandom_range(0, 99) < 15) begin
         send_item(REQ_READ, 6'($urandom), rand_digest(), rand_digest(), 4'($urandom),
                   5'($urandom));
      end else begin
         node = ($urandom_range(0, 19) == 0) ? rand_digest()
                                             : key_pool[$urandom_range(0, KEY_POOL - 1)];
         send_item(REQ_RECORD, 6'($urandom), node, rand_digest(), 4'($urandom),
                   5'($urandom));
      end
   endtask

   task automatic test_directed();
      set_masks(64'h8000_0000_0000_0003, 64'h8000_0000_0000_0006);
      // class in both masks counts as support
      send_item(REQ_RECORD, 6'd1, '0, '1, '0, '0);
      send_item(REQ_RECORD, 6'd2, '0, '0, '0, '0);
      send_item(REQ_RECORD, 6'd63, '1, '1, '1, '1);
      send_item(REQ_RECORD, 6'd0, '1, key_pool[3], '0, '0);
      // ignored class
      send_item(REQ_RECORD, 6'd10, key_pool[5], rand_digest(), '0, '0);
      send_item(REQ_READ, '0, '0, '0, 4'd0, 5'd0);
      send_item(REQ_READ, '0, '0, '0, 4'd0, 5'd1);
      send_item(REQ_READ, '0, '0, '0, 4'd0, 5'd9);
      send_item(REQ_READ, '0, '0, '0, 4'd1, 5'd10);
      send_item(REQ_READ, '0, '0, '0, 4'd0, 5'd31);
      send_item(REQ_READ, '0, '0, '0, 4'd0, 5'd17);
      send_item(REQ_READ, '0, '0, '0, 4'd15, 5'd0);
      // fill one support list past its end
      for (int i = 0; i < 9; i++)
         send_item(REQ_RECORD, 6'd0, key_pool[0], rand_digest(), '0, '0);
      send_item(REQ_READ, '0, '0, '0, 4'd2, 5'd8);
      send_item(REQ_READ, '0, '0, '0, 4'd2, 5'd16);
   endtask

   task automatic test_random_phase(int count, logic [63:0] sup, logic [63:0] con);
      set_masks(sup, con);
      repeat (count) send_random_item();
   endtask

   task automatic test_backpressure();
      wait_idle();
      long_hold = 1;
      repeat (40) send_random_item();
   endtask

   initial begin
      grouper_result_type got;
      grouper_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_record_index, rsp_created, rsp_polarity, rsp_edge_slot,
                   rsp_support_count, rsp_contradiction_count, rsp_record_count,
                   rsp_data_w3, rsp_data_w2, rsp_data_w1, rsp_data_w0};
            results_seen++;
            status_seen[got.status]++;
            if (pending_results.size() == 0) begin
               $display("%0t unexpected transaction: %h", $time, got);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  $display("%0t mismatch expected %h actual %h", $time, want, got);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1;
            for (hold = 0; hold < 400; hold++) @(negedge clock);
            rsp_stall = 0;
            long_hold = 0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall = 0;
         end else begin
            rsp_stall = 0;
         end
      end
   end

   initial begin
      support_mask = '0;
      contra_mask = '0;
      records_used = 0;
      foreach (support_cnt[i]) begin
         support_cnt[i] = 0;
         contra_cnt[i] = 0;
      end
      foreach (key_pool[i]) key_pool[i] = rand_digest();
      key_pool[1] = '0;
      key_pool[2] = '1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_random_phase(400, {$urandom, $urandom}, {$urandom, $urandom});
      test_backpressure();
      test_random_phase(400, '1, '0);
      test_random_phase(400, '0, '1);
      wait_idle();
      idling = 0;
      test_random_phase(400, {$urandom, $urandom}, {$urandom, $urandom});
      wait_idle();
      repeat (30) @(posedge clock);
      $display("covered %0d transactions: ok %0d, ignored %0d, list full %0d", results_seen,
               status_seen[ST_OK], status_seen[ST_IGNORED], status_seen[ST_LIST_FULL]);
      $display("table full %0d, read invalid %0d, records in use %0d",
               status_seen[ST_TABLE_FULL], status_seen[ST_READ_INVALID], records_used);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
